// ===== rtl/core/seas_pkg.sv =====
`timescale 1ns / 1ps

package seas_pkg;

   // Field widths of the channels.
   localparam int CMD_W      = 2;
   localparam int ADDR_W     = 24;
   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 2;
   localparam int REG_IDX_W  = 3;

   // Address bits kept from a request; the rest are dropped (range 16 to 24).
   localparam int ADDR_BITS  = 24;

   // Request command codes.
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REPLY = 2'd2;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_SEND       = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ_DONE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WRITE_DONE = 2'd2;

   // Register indexes.
   localparam logic [REG_IDX_W-1:0] REG_THREE_BYTE = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_READ_OP    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_WRITE_OP   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ENABLE_OP  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_STATUS_OP  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_FILLER     = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_BUSY_MASK  = 3'd6;

   // Register reset values.
   localparam logic              RST_THREE_BYTE = 1'b1;
   localparam logic [BYTE_W-1:0] RST_READ_OP    = 8'h03;
   localparam logic [BYTE_W-1:0] RST_WRITE_OP   = 8'h02;
   localparam logic [BYTE_W-1:0] RST_ENABLE_OP  = 8'h06;
   localparam logic [BYTE_W-1:0] RST_STATUS_OP  = 8'h05;
   localparam logic [BYTE_W-1:0] RST_FILLER     = 8'h00;
   localparam logic [BYTE_W-1:0] RST_BUSY_MASK  = 8'h01;

endpackage

// ===== rtl/core/seas_ifs.sv =====
`timescale 1ns / 1ps

interface seas_req_if;
   logic                          valid;
   logic                          ready;
   logic [seas_pkg::CMD_W-1:0]    cmd;
   logic [seas_pkg::ADDR_W-1:0]   address;
   logic [seas_pkg::BYTE_W-1:0]   write_data;
   logic [seas_pkg::BYTE_W-1:0]   reply_byte;

   modport source (output valid, output cmd, output address, output write_data,
                   output reply_byte, input ready);
   modport sink   (input valid, input cmd, input address, input write_data,
                   input reply_byte, output ready);
endinterface

interface seas_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [seas_pkg::KIND_W-1:0]   result_kind;
   logic [seas_pkg::BYTE_W-1:0]   out_byte;
   logic                          frame_end;

   modport source (output valid, output result_kind, output out_byte,
                   output frame_end, input ready);
   modport sink   (input valid, input result_kind, input out_byte,
                   input frame_end, output ready);
endinterface

interface seas_csr_if;
   logic                            valid;
   logic                            ready;
   logic [seas_pkg::REG_IDX_W-1:0]  reg_index;
   logic [seas_pkg::BYTE_W-1:0]     write_value;

   modport source (output valid, output reg_index, output write_value, input ready);
   modport sink   (input valid, input reg_index, input write_value, output ready);
endinterface

// ===== rtl/core/spi_eeprom_access_sequencer_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// req_chan  in         cmd, address, write_data, reply_byte
// rsp_chan  out        result_kind, out_byte, frame_end (zero or one per req beat)
// csr_chan  in         reg_index, write_value (always ready)
//
// One req beat is taken every cycle while the input register is empty or the result
// register is free; a result passes through the input register, the phase logic and the result register.
// Reset clears the phase machine, the valid flags and the configuration registers to defaults.
// A stalled rsp_chan holds its beat; req_chan keeps accepting while the result
// register can drain in the same cycle, so only a held result backs up the input.

module spi_eeprom_access_sequencer_top (
   input  logic             clock,
   input  logic             reset,
   seas_req_if.sink         req_chan,
   seas_rsp_if.source       rsp_chan,
   seas_csr_if.sink         csr_chan
);

   // Phase of the current access. Codes 7 and above never occur.
   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_POLL_CMD  = 3'd1,
      PH_POLL_FILL = 3'd2,
      PH_ENABLE    = 3'd3,
      PH_OPCODE    = 3'd4,
      PH_ADDR      = 3'd5,
      PH_LAST      = 3'd6
   } phase_type;

   // Configuration registers.
   logic                              three_byte_ff;
   logic [seas_pkg::BYTE_W-1:0]       read_op_ff;
   logic [seas_pkg::BYTE_W-1:0]       write_op_ff;
   logic [seas_pkg::BYTE_W-1:0]       enable_op_ff;
   logic [seas_pkg::BYTE_W-1:0]       status_op_ff;
   logic [seas_pkg::BYTE_W-1:0]       filler_ff;
   logic [seas_pkg::BYTE_W-1:0]       busy_mask_ff;

   // Input register.
   logic                              in_valid_ff, in_valid_in;
   logic [seas_pkg::CMD_W-1:0]        in_cmd_ff;
   logic [seas_pkg::ADDR_BITS-1:0]    in_address_ff;
   logic [seas_pkg::BYTE_W-1:0]       in_data_ff;
   logic [seas_pkg::BYTE_W-1:0]       in_reply_ff;

   // Access state.
   phase_type                         phase_ff, phase_in;
   logic [seas_pkg::ADDR_BITS-1:0]    held_address_ff, held_address_in;
   logic [seas_pkg::BYTE_W-1:0]       held_data_ff, held_data_in;
   logic                              is_write_ff, is_write_in;
   logic [1:0]                        byte_pos_ff, byte_pos_in;

   // Result register.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [seas_pkg::KIND_W-1:0]       rsp_kind_ff, rsp_kind_in;
   logic [seas_pkg::BYTE_W-1:0]       rsp_byte_ff, rsp_byte_in;
   logic                              rsp_end_ff, rsp_end_in;

   logic                              req_fire;
   logic                              out_free;
   logic                              advance;
   logic                              emit;
   logic [1:0]                        last_pos;
   logic [2:0]                        pos_plus_one;

   // Picks address byte idx (0 is the lowest) from the held address.
   function automatic logic [seas_pkg::BYTE_W-1:0] addr_byte(
      input logic [seas_pkg::ADDR_BITS-1:0] addr,
      input logic [1:0]                     idx
   );
      logic [seas_pkg::ADDR_W-1:0] wide;
      logic [seas_pkg::BYTE_W-1:0] sel;
      wide = seas_pkg::ADDR_W'(addr);
      unique case (idx)
         2'd0:    sel = wide[7:0];
         2'd1:    sel = wide[15:8];
         default: sel = wide[23:16];
      endcase
      return sel;
   endfunction

   assign csr_chan.ready = 1'b1;

   // The result register can take a new beat when empty or draining now.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign in_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   // Index of the last address byte: 2 with three address bytes, 1 with two.
   assign last_pos     = three_byte_ff ? 2'd2 : 2'd1;
   assign pos_plus_one = {1'b0, byte_pos_ff} + 3'd1;

   // Phase step for the beat in the input register.
   always_comb begin
      phase_in        = phase_ff;
      held_address_in = held_address_ff;
      held_data_in    = held_data_ff;
      is_write_in     = is_write_ff;
      byte_pos_in     = byte_pos_ff;
      emit            = 1'b0;
      rsp_kind_in     = seas_pkg::KIND_SEND;
      rsp_byte_in     = '0;
      rsp_end_in      = 1'b0;

      if (in_cmd_ff == seas_pkg::CMD_READ || in_cmd_ff == seas_pkg::CMD_WRITE) begin
         // A new request starts only when no access is in progress.
         if (phase_ff == PH_IDLE) begin
            held_address_in = in_address_ff;
            held_data_in    = in_data_ff;
            is_write_in     = (in_cmd_ff == seas_pkg::CMD_WRITE);
            byte_pos_in     = 2'd0;
            phase_in        = PH_POLL_CMD;
            emit            = 1'b1;
            rsp_byte_in     = status_op_ff;
         end
      end else if (in_cmd_ff == seas_pkg::CMD_REPLY) begin
         unique case (phase_ff)
            PH_POLL_CMD: begin
               phase_in    = PH_POLL_FILL;
               emit        = 1'b1;
               rsp_byte_in = filler_ff;
               rsp_end_in  = 1'b1;
            end
            PH_POLL_FILL: begin
               emit = 1'b1;
               if ((in_reply_ff & busy_mask_ff) != '0) begin
                  // Device still busy: poll the status register again.
                  phase_in    = PH_POLL_CMD;
                  rsp_byte_in = status_op_ff;
               end else if (is_write_ff) begin
                  phase_in    = PH_ENABLE;
                  rsp_byte_in = enable_op_ff;
                  rsp_end_in  = 1'b1;
               end else begin
                  phase_in    = PH_OPCODE;
                  rsp_byte_in = read_op_ff;
               end
            end
            PH_ENABLE: begin
               phase_in    = PH_OPCODE;
               emit        = 1'b1;
               rsp_byte_in = write_op_ff;
            end
            PH_OPCODE: begin
               byte_pos_in = 2'd0;
               phase_in    = PH_ADDR;
               emit        = 1'b1;
               rsp_byte_in = addr_byte(held_address_ff, last_pos);
            end
            PH_ADDR: begin
               emit = 1'b1;
               if (pos_plus_one <= {1'b0, last_pos}) begin
                  // Address bytes go out high first.
                  byte_pos_in = pos_plus_one[1:0];
                  rsp_byte_in = addr_byte(held_address_ff, last_pos - pos_plus_one[1:0]);
               end else begin
                  phase_in    = PH_LAST;
                  rsp_byte_in = is_write_ff ? held_data_ff : filler_ff;
                  rsp_end_in  = 1'b1;
               end
            end
            PH_LAST: begin
               phase_in    = PH_IDLE;
               byte_pos_in = 2'd0;
               emit        = 1'b1;
               if (is_write_ff) begin
                  rsp_kind_in = seas_pkg::KIND_WRITE_DONE;
               end else begin
                  rsp_kind_in = seas_pkg::KIND_READ_DONE;
                  rsp_byte_in = in_reply_ff;
               end
            end
            default: begin
               // A reply with no access in progress is dropped.
               phase_in = phase_ff;
            end
         endcase
      end
   end

   assign rsp_valid_in = advance ? emit : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         three_byte_ff <= seas_pkg::RST_THREE_BYTE;
         read_op_ff    <= seas_pkg::RST_READ_OP;
         write_op_ff   <= seas_pkg::RST_WRITE_OP;
         enable_op_ff  <= seas_pkg::RST_ENABLE_OP;
         status_op_ff  <= seas_pkg::RST_STATUS_OP;
         filler_ff     <= seas_pkg::RST_FILLER;
         busy_mask_ff  <= seas_pkg::RST_BUSY_MASK;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            seas_pkg::REG_THREE_BYTE: three_byte_ff <= csr_chan.write_value[0];
            seas_pkg::REG_READ_OP:    read_op_ff    <= csr_chan.write_value;
            seas_pkg::REG_WRITE_OP:   write_op_ff   <= csr_chan.write_value;
            seas_pkg::REG_ENABLE_OP:  enable_op_ff  <= csr_chan.write_value;
            seas_pkg::REG_STATUS_OP:  status_op_ff  <= csr_chan.write_value;
            seas_pkg::REG_FILLER:     filler_ff     <= csr_chan.write_value;
            seas_pkg::REG_BUSY_MASK:  busy_mask_ff  <= csr_chan.write_value;
            default: begin
               // Writes beyond the register list are dropped.
               busy_mask_ff <= busy_mask_ff;
            end
         endcase
      end
   end

   // Input register payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff     <= req_chan.cmd;
         in_address_ff <= req_chan.address[seas_pkg::ADDR_BITS-1:0];
         in_data_ff    <= req_chan.write_data;
         in_reply_ff   <= req_chan.reply_byte;
      end
   end

   // Phase machine, access state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         phase_ff        <= PH_IDLE;
         held_address_ff <= '0;
         held_data_ff    <= '0;
         is_write_ff     <= 1'b0;
         byte_pos_ff     <= 2'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff        <= phase_in;
            held_address_ff <= held_address_in;
            held_data_ff    <= held_data_in;
            is_write_ff     <= is_write_in;
            byte_pos_ff     <= byte_pos_in;
         end
      end
      if (advance && emit) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_end_ff  <= rsp_end_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_kind = rsp_kind_ff;
   assign rsp_chan.out_byte    = rsp_byte_ff;
   assign rsp_chan.frame_end   = rsp_end_ff;

endmodule

// ===== rtl/core/seas_checker.sv =====
`timescale 1ns / 1ps

module seas_props (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [seas_pkg::KIND_W-1:0]       rsp_result_kind,
   input logic [seas_pkg::BYTE_W-1:0]       rsp_out_byte,
   input logic                              rsp_frame_end
);

   // A held result beat keeps its contents until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_out_byte) && $stable(rsp_frame_end))
      else $error("result beat changed while stalled");

   // Nothing is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Only the three defined kinds appear.
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_kind == seas_pkg::KIND_SEND
         || rsp_result_kind == seas_pkg::KIND_READ_DONE
         || rsp_result_kind == seas_pkg::KIND_WRITE_DONE))
      else $error("undefined result kind");

   // Completion beats never end a bus frame, and a write completion carries zero.
   a_done_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != seas_pkg::KIND_SEND |->
         !rsp_frame_end && (rsp_result_kind != seas_pkg::KIND_WRITE_DONE
         || rsp_out_byte == '0))
      else $error("malformed completion beat");

endmodule

bind spi_eeprom_access_sequencer_top seas_props u_seas_props (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_result_kind (rsp_chan.result_kind),
   .rsp_out_byte    (rsp_chan.out_byte),
   .rsp_frame_end   (rsp_chan.frame_end)
);
